@@ hdl/ptlf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed sizes for the point-to-local-frame datapath.
// No dependencies; the cells, the unit-vector engine and the top level import it.
package ptlf_pkg;

  // Axis normalization puts the largest component magnitude in [2^29, 2^30).
  localparam int unsigned NORM_MSB   = 29;
  localparam int unsigned ABS_W      = 30;
  localparam int unsigned SH_W       = 5;
  // Square root of the scaled squared length, one result bit per cell.
  localparam int unsigned SQ_W       = 63;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned ROOT_W     = 31;
  // Unit vector components carry UNIT_FRAC fraction bits.
  localparam int unsigned UNIT_FRAC  = 28;
  localparam int unsigned UNIT_W     = 30;
  localparam int unsigned K_W        = 31;
  // Restoring divider: one quotient bit per cell.
  localparam int unsigned QUO_W      = 29;
  localparam int unsigned REM_W      = 31;
  localparam int unsigned NUM_W      = 59;
  // Register stages of one unit-vector engine, input to output.
  localparam int unsigned UNIT_LAT   = 6 + SQRT_STEPS + 1 + QUO_W + 1;

  typedef logic [ABS_W-1:0] abs_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0]    den;
    div_lane_t [2:0]      lane;
  } div_t;

  typedef struct packed {
    logic       zero;
    unit_t [2:0] u;
  } unit_vec_t;

endpackage

@@ hdl/ptlf_point_if.sv @@
`timescale 1ns / 1ps
// Input channel of the point-to-local-frame block: frame points and the point.
// Standalone interface, no dependencies.
interface ptlf_point_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] first_axis_x;
  logic signed [COORD_WIDTH-1:0] first_axis_y;
  logic signed [COORD_WIDTH-1:0] first_axis_z;
  logic signed [COORD_WIDTH-1:0] second_axis_x;
  logic signed [COORD_WIDTH-1:0] second_axis_y;
  logic signed [COORD_WIDTH-1:0] second_axis_z;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, first_axis_x, first_axis_y, first_axis_z,
           second_axis_x, second_axis_y, second_axis_z, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, first_axis_x, first_axis_y, first_axis_z,
           second_axis_x, second_axis_y, second_axis_z, point_x, point_y, point_z,
    output ready
  );
endinterface

@@ hdl/ptlf_local_if.sv @@
`timescale 1ns / 1ps
// Output channel of the point-to-local-frame block: local coordinates.
// Standalone interface, no dependencies.
interface ptlf_local_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] local_first;
  logic signed [COORD_WIDTH-1:0] local_second;
  logic signed [COORD_WIDTH-1:0] local_third;
  logic                          degenerate;

  modport source (
    output valid, local_first, local_second, local_third, degenerate,
    input  ready
  );
  modport sink (
    input  valid, local_first, local_second, local_third, degenerate,
    output ready
  );
endinterface

@@ hdl/ptlf_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One registered step of the bit-pair integer square root.
// Depends on ptlf_pkg.
module ptlf_sqrt_cell import ptlf_pkg::*; #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t st_i,
  output sqrt_t st_o
);

  sqrt_t st_d, st_q;
  logic [SQ_W-1:0] bit_v, trial;

  always_comb begin
    bit_v = SQ_W'(1) << BIT_POS;
    trial = st_i.root + bit_v;
    if (st_i.rem >= trial) begin
      st_d.rem  = st_i.rem - trial;
      st_d.root = (st_i.root >> 1) + bit_v;
    end else begin
      st_d.rem  = st_i.rem;
      st_d.root = st_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ hdl/ptlf_div_cell.sv @@
`timescale 1ns / 1ps
// One registered step of a three-lane restoring divider with a shared divisor.
// Depends on ptlf_pkg.
module ptlf_div_cell import ptlf_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t st_i,
  output div_t st_o
);

  div_t st_d, st_q;
  logic [REM_W:0] trial;
  logic [REM_W:0] den_x;
  logic           take;

  always_comb begin
    trial = '0;
    take  = 1'b0;
    den_x = (REM_W + 1)'(st_i.den);
    st_d.den = st_i.den;
    for (int c = 0; c < 3; c++) begin
      trial = {st_i.lane[c].rem, st_i.lane[c].low[QUO_W-1]};
      take  = trial >= den_x;
      st_d.lane[c].rem = take ? REM_W'(trial - den_x) : REM_W'(trial);
      st_d.lane[c].low = st_i.lane[c].low << 1;
      st_d.lane[c].quo = {st_i.lane[c].quo[QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ hdl/ptlf_unit_vec.sv @@
`timescale 1ns / 1ps
// Unit-vector engine: normalize, square, root chain, divider chain, sign.
// Depends on ptlf_pkg, ptlf_sqrt_cell and ptlf_div_cell.
module ptlf_unit_vec import ptlf_pkg::*; #(
  parameter int unsigned DIFF_WIDTH = 25
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2:0][DIFF_WIDTH-1:0] d_i,
  output unit_vec_t                  vec_o
);

  localparam int unsigned POS_W  = $clog2(DIFF_WIDTH);
  localparam int unsigned WIDE_W = DIFF_WIDTH + NORM_MSB;

  typedef struct packed {
    abs_t [2:0] a;
    logic [2:0] sgn;
    logic       zero;
  } side_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
  } fin_t;

  logic [DIFF_WIDTH-1:0] mag1_q [3], mag2_q [3], mag3_q [3];
  logic [2:0]            sgn1_q, sgn2_q, sgn3_q, sgn4_q, sgn5_q;
  logic [DIFF_WIDTH-1:0] m2_d, m2_q;
  logic [POS_W-1:0]      pos;
  logic                  lft3_d, lft3_q, zero3_q, zero4_q, zero5_q;
  logic [SH_W-1:0]       amt3_d, amt3_q;
  logic [WIDE_W-1:0]     wide;
  abs_t                  a4_d [3];
  abs_t                  a4_q [3], a5_q [3];
  logic [2*ABS_W-1:0]    sq5_q [3];
  sqrt_t                 sq [SQRT_STEPS+1];
  side_t                 side_q [SQRT_STEPS+1];
  logic [ROOT_W-1:0]     root;
  logic [NUM_W-1:0]      num [3];
  div_t                  div0_d;
  div_t                  dv [QUO_W+1];
  fin_t                  fin_q [QUO_W+1];
  unit_vec_t             vec_d, vec_q;

  // Magnitudes and signs of the axis difference.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        mag1_q[c] <= d_i[c][DIFF_WIDTH-1] ? (~d_i[c] + DIFF_WIDTH'(1)) : d_i[c];
        sgn1_q[c] <= d_i[c][DIFF_WIDTH-1];
      end
    end
  end

  always_comb begin
    m2_d = mag1_q[0];
    if (mag1_q[1] > m2_d) begin
      m2_d = mag1_q[1];
    end
    if (mag1_q[2] > m2_d) begin
      m2_d = mag1_q[2];
    end
  end

  always_comb begin
    pos = '0;
    for (int b = 0; b < DIFF_WIDTH; b++) begin
      if (m2_q[b]) begin
        pos = POS_W'(b);
      end
    end
    lft3_d = int'(pos) < NORM_MSB;
    amt3_d = lft3_d ? SH_W'(NORM_MSB - int'(pos)) : SH_W'(int'(pos) - NORM_MSB);
  end

  always_comb begin
    wide = '0;
    for (int c = 0; c < 3; c++) begin
      wide    = WIDE_W'(mag3_q[c]);
      wide    = lft3_q ? (wide << amt3_q) : (wide >> amt3_q);
      a4_d[c] = wide[ABS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_q    <= m2_d;
      mag2_q  <= mag1_q;
      sgn2_q  <= sgn1_q;
      lft3_q  <= lft3_d;
      amt3_q  <= amt3_d;
      zero3_q <= (m2_q == '0);
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      a4_q    <= a4_d;
      sgn4_q  <= sgn3_q;
      zero4_q <= zero3_q;
      for (int c = 0; c < 3; c++) begin
        sq5_q[c] <= (2 * ABS_W)'(a4_q[c]) * (2 * ABS_W)'(a4_q[c]);
      end
      a5_q    <= a4_q;
      sgn5_q  <= sgn4_q;
      zero5_q <= zero4_q;
      sq[0].rem  <= SQ_W'(sq5_q[0]) + SQ_W'(sq5_q[1]) + SQ_W'(sq5_q[2]);
      sq[0].root <= '0;
      for (int c = 0; c < 3; c++) begin
        side_q[0].a[c] <= a5_q[c];
      end
      side_q[0].sgn  <= sgn5_q;
      side_q[0].zero <= zero5_q;
      for (int s = 1; s <= SQRT_STEPS; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ptlf_sqrt_cell #(
      .BIT_POS(2 * (SQRT_STEPS - 1 - k))
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en_i),
      .st_i (sq[k]),
      .st_o (sq[k+1])
    );
  end

  // Rounded division: (a * 2^UNIT_FRAC + floor(r / 2)) / r.
  always_comb begin
    root       = sq[SQRT_STEPS].root[ROOT_W-1:0];
    div0_d.den = root;
    for (int c = 0; c < 3; c++) begin
      num[c] = (NUM_W'(side_q[SQRT_STEPS].a[c]) << UNIT_FRAC) + NUM_W'(root >> 1);
      div0_d.lane[c].rem = REM_W'(num[c][NUM_W-1:QUO_W]);
      div0_d.lane[c].low = num[c][QUO_W-1:0];
      div0_d.lane[c].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv[0]         <= div0_d;
      fin_q[0].sgn  <= side_q[SQRT_STEPS].sgn;
      fin_q[0].zero <= side_q[SQRT_STEPS].zero;
      for (int s = 1; s <= QUO_W; s++) begin
        fin_q[s] <= fin_q[s-1];
      end
      vec_q <= vec_d;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    ptlf_div_cell u_cell (
      .clk_i(clk_i),
      .en_i (en_i),
      .st_i (dv[k]),
      .st_o (dv[k+1])
    );
  end

  always_comb begin
    vec_d.zero = fin_q[QUO_W].zero;
    for (int c = 0; c < 3; c++) begin
      vec_d.u[c] = fin_q[QUO_W].sgn[c] ? -UNIT_W'(dv[QUO_W].lane[c].quo)
                                        : UNIT_W'(dv[QUO_W].lane[c].quo);
    end
  end

  assign vec_o = vec_q;

endmodule

@@ hdl/point_to_local_frame.sv @@
`timescale 1ns / 1ps
// Point-to-local-frame transform: top level with difference, cross product,
// projection and output stages. Depends on ptlf_pkg, both interfaces and
// ptlf_unit_vec.
//
// Usage: each beat on pt_i carries an origin B, two axis points C and E and a
// point P. The block builds unit vectors i (B toward C) and j (B toward E),
// k = i x j, and returns on res_o the projections of P - B on i, j and k,
// rounded to nearest and saturated to the coordinate range. When C equals B
// or E equals B, degenerate is set and the three coordinates are zero.
// j is not orthogonalized, so k is not unit length for skewed axes.
//
// Most of the path from an accepted input beat to its output beat lies in the
// two cell chains of each unit-vector engine: 32 square root cells and 29
// divider cells, one result bit per cell. Throughput is one beat per cycle while
// res_o does not stall; beats of successive points move through the chains together.
//
// When res_o stalls, the whole pipeline holds, and pt_i.ready stays high as
// long as the output register is empty or is being drained in that cycle.
// Reset clears only the valid bits; no beat is in flight after reset.
module point_to_local_frame import ptlf_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptlf_point_if.sink        pt_i,
  ptlf_local_if.source      res_o
);

  localparam int unsigned DIFF_W   = COORD_WIDTH + 1;
  localparam int unsigned XP_W     = 2 * UNIT_W;
  localparam int unsigned XD_W     = XP_W + 1;
  localparam int unsigned PROD_W   = K_W + DIFF_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned PIPE_LAT = 1 + UNIT_LAT + 5;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [K_W-1:0]    axis_t;

  logic en, fire;
  logic [PIPE_LAT-1:0] vld_q;

  logic signed [COORD_WIDTH-1:0] org [3], c_pt [3], e_pt [3], p_pt [3];
  diff_t dc_q [3], de_q [3];
  diff_t q_line_q [UNIT_LAT+1][3];
  unit_vec_t vec_i, vec_j;
  unit_t ui [3], uj [3];

  // Cross product stages.
  logic signed [XP_W-1:0] xp_q [6];
  unit_t  ui1_q [3], uj1_q [3];
  logic   zero1_q, zero2_q, zero3_q, zero4_q;
  diff_t  q1_q [3], q2_q [3];
  logic signed [XD_W-1:0] xd;
  logic [XD_W-1:0]        xmag, xrnd;
  axis_t  ax_d [3][3];
  axis_t  ax_q [3][3];

  // Projection stages.
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic [SUM_W-1:0]         smag, srnd;
  logic signed [COORD_WIDTH-1:0] res_d [3];
  logic signed [COORD_WIDTH-1:0] res_q [3];
  logic deg_q;

  // The pipeline advances whenever the output register can take a beat.
  assign en         = !vld_q[PIPE_LAT-1] || res_o.ready;
  assign pt_i.ready = en;
  assign fire       = pt_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], fire};
    end
  end

  always_comb begin
    org[0]  = pt_i.origin_x;      org[1]  = pt_i.origin_y;      org[2]  = pt_i.origin_z;
    c_pt[0] = pt_i.first_axis_x;  c_pt[1] = pt_i.first_axis_y;  c_pt[2] = pt_i.first_axis_z;
    e_pt[0] = pt_i.second_axis_x; e_pt[1] = pt_i.second_axis_y; e_pt[2] = pt_i.second_axis_z;
    p_pt[0] = pt_i.point_x;       p_pt[1] = pt_i.point_y;       p_pt[2] = pt_i.point_z;
  end

  // Exact differences from the origin; the point difference rides alongside
  // the unit-vector engines until the projections need it.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dc_q[c]        <= DIFF_W'(c_pt[c]) - DIFF_W'(org[c]);
        de_q[c]        <= DIFF_W'(e_pt[c]) - DIFF_W'(org[c]);
        q_line_q[0][c] <= DIFF_W'(p_pt[c]) - DIFF_W'(org[c]);
      end
      for (int s = 1; s <= UNIT_LAT; s++) begin
        q_line_q[s] <= q_line_q[s-1];
      end
    end
  end

  ptlf_unit_vec #(
    .DIFF_WIDTH(DIFF_W)
  ) u_first_axis (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({dc_q[2], dc_q[1], dc_q[0]}),
    .vec_o(vec_i)
  );

  ptlf_unit_vec #(
    .DIFF_WIDTH(DIFF_W)
  ) u_second_axis (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({de_q[2], de_q[1], de_q[0]}),
    .vec_o(vec_j)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ui[c] = vec_i.u[c];
      uj[c] = vec_j.u[c];
    end
  end

  // Cross product: partial products first, then difference and rounding.
  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q[0] <= ui[1] * uj[2];
      xp_q[1] <= ui[2] * uj[1];
      xp_q[2] <= ui[2] * uj[0];
      xp_q[3] <= ui[0] * uj[2];
      xp_q[4] <= ui[0] * uj[1];
      xp_q[5] <= ui[1] * uj[0];
      ui1_q   <= ui;
      uj1_q   <= uj;
      zero1_q <= vec_i.zero || vec_j.zero;
      q1_q    <= q_line_q[UNIT_LAT];
    end
  end

  always_comb begin
    xd   = '0;
    xmag = '0;
    xrnd = '0;
    for (int c = 0; c < 3; c++) begin
      ax_d[0][c] = K_W'(ui1_q[c]);
      ax_d[1][c] = K_W'(uj1_q[c]);
      xd   = XD_W'(xp_q[2*c]) - XD_W'(xp_q[2*c+1]);
      xmag = xd[XD_W-1] ? XD_W'(-xd) : XD_W'(xd);
      xrnd = (xmag + (XD_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      ax_d[2][c] = xd[XD_W-1] ? -K_W'(xrnd) : K_W'(xrnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q    <= ax_d;
      zero2_q <= zero1_q;
      q2_q    <= q1_q;
    end
  end

  // Projections: nine products, then three sums.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= PROD_W'(ax_q[r][c]) * PROD_W'(q2_q[c]);
        end
        sum_q[r] <= SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
      end
      zero3_q <= zero2_q;
      zero4_q <= zero3_q;
    end
  end

  // Round to nearest, ties away from zero, then saturate; a degenerate
  // frame forces all three coordinates to zero.
  always_comb begin
    smag = '0;
    srnd = '0;
    for (int r = 0; r < 3; r++) begin
      smag = sum_q[r][SUM_W-1] ? SUM_W'(-sum_q[r]) : SUM_W'(sum_q[r]);
      srnd = (smag + (SUM_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      if (zero4_q) begin
        res_d[r] = '0;
      end else if (sum_q[r][SUM_W-1]) begin
        if (srnd > (SUM_W'(1) << (COORD_WIDTH - 1))) begin
          res_d[r] = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        end else begin
          res_d[r] = -COORD_WIDTH'(srnd);
        end
      end else begin
        if (srnd > ((SUM_W'(1) << (COORD_WIDTH - 1)) - SUM_W'(1))) begin
          res_d[r] = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        end else begin
          res_d[r] = COORD_WIDTH'(srnd);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      deg_q <= zero4_q;
    end
  end

  assign res_o.valid        = vld_q[PIPE_LAT-1];
  assign res_o.local_first  = res_q[0];
  assign res_o.local_second = res_q[1];
  assign res_o.local_third  = res_q[2];
  assign res_o.degenerate   = deg_q;

endmodule

@@ verif/ptlf_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the point-to-local-frame block: watches both channels, predicts
// the local coordinates of each accepted point beat and compares them in order.
// Depends on ptlf_point_if and ptlf_local_if.
module ptlf_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  ptlf_point_if  pt,
  ptlf_local_if  res,
  output int     fail_cnt_o,
  output int     pending_o
);
  localparam int  CW     = 24;
  localparam int  UFRAC  = 28;
  localparam longint ONE_U = longint'(1) << UFRAC;

  typedef struct packed {
    logic signed [CW-1:0] first;
    logic signed [CW-1:0] second;
    logic signed [CW-1:0] third;
    logic                 degen;
  } local_t;

  local_t coord_q[$];
  int     fails;

  assign fail_cnt_o = fails;
  assign pending_o  = coord_q.size();

  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scales the axis so its largest magnitude sits in [2^29, 2^30), then divides
  // by the rounded-down length. Returns 0 for a zero-length axis.
  function automatic bit unit_axis(input longint d[3], output longint u[3]);
    longint m;
    longint a;
    longint ds[3];
    longint unsigned n;
    longint unsigned r;
    int left;
    int right;
    m = 0; n = 0; left = 0; right = 0;
    for (int c = 0; c < 3; c++) begin
      a = (d[c] < 0) ? -d[c] : d[c];
      if (a > m) m = a;
    end
    for (int c = 0; c < 3; c++) u[c] = 0;
    if (m == 0) return 0;
    while (m < (longint'(1) << 29)) begin m = m << 1; left++; end
    while (m >= (longint'(1) << 30)) begin m = m >> 1; right++; end
    for (int c = 0; c < 3; c++) begin
      a = (d[c] < 0) ? -d[c] : d[c];
      a = (a << left) >> right;
      ds[c] = (d[c] < 0) ? -a : a;
      n += longint'(a) * longint'(a);
    end
    r = int_sqrt(n);
    for (int c = 0; c < 3; c++) u[c] = round_div(ds[c] * ONE_U, longint'(r));
    return 1;
  endfunction

  function automatic logic signed [CW-1:0] project_sat(input longint u[3],
                                                       input longint q[3]);
    longint s;
    longint v;
    s = u[0] * q[0] + u[1] * q[1] + u[2] * q[2];
    v = round_div(s, ONE_U);
    if (v > (longint'(1) << (CW - 1)) - 1) v = (longint'(1) << (CW - 1)) - 1;
    if (v < -(longint'(1) << (CW - 1))) v = -(longint'(1) << (CW - 1));
    return v[CW-1:0];
  endfunction

  function automatic local_t predict_local(input longint b[3], input longint c_pt[3],
                                           input longint e_pt[3], input longint p[3]);
    longint dc[3], de[3], q[3], ui[3], uj[3], uk[3];
    local_t r;
    bit ok_i;
    bit ok_j;
    for (int c = 0; c < 3; c++) begin
      dc[c] = c_pt[c] - b[c];
      de[c] = e_pt[c] - b[c];
      q[c]  = p[c] - b[c];
    end
    ok_i = unit_axis(dc, ui);
    ok_j = unit_axis(de, uj);
    r = '0;
    if (!ok_i || !ok_j) begin
      r.degen = 1'b1;
      return r;
    end
    uk[0] = round_div(ui[1] * uj[2] - ui[2] * uj[1], ONE_U);
    uk[1] = round_div(ui[2] * uj[0] - ui[0] * uj[2], ONE_U);
    uk[2] = round_div(ui[0] * uj[1] - ui[1] * uj[0], ONE_U);
    r.first  = project_sat(ui, q);
    r.second = project_sat(uj, q);
    r.third  = project_sat(uk, q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint b[3], c_pt[3], e_pt[3], p[3];
    local_t exp_r;
    local_t got_r;
    if (!rst_ni) begin
      fails = 0;
    end else begin
      if (pt.valid && pt.ready) begin
        b[0] = pt.origin_x;      b[1] = pt.origin_y;      b[2] = pt.origin_z;
        c_pt[0] = pt.first_axis_x;  c_pt[1] = pt.first_axis_y;  c_pt[2] = pt.first_axis_z;
        e_pt[0] = pt.second_axis_x; e_pt[1] = pt.second_axis_y; e_pt[2] = pt.second_axis_z;
        p[0] = pt.point_x;       p[1] = pt.point_y;       p[2] = pt.point_z;
        coord_q = {coord_q, predict_local(b, c_pt, e_pt, p)};
      end
      if (res.valid && res.ready) begin
        got_r = '{res.local_first, res.local_second, res.local_third, res.degenerate};
        if (coord_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got_r);
          fails++;
        end else begin
          exp_r = coord_q.pop_front();
          if (got_r.first !== exp_r.first) begin
            $display("%0t: local_first exp %0d got %0d", $time, exp_r.first, got_r.first);
            fails++;
          end
          if (got_r.second !== exp_r.second) begin
            $display("%0t: local_second exp %0d got %0d", $time, exp_r.second, got_r.second);
            fails++;
          end
          if (got_r.third !== exp_r.third) begin
            $display("%0t: local_third exp %0d got %0d", $time, exp_r.third, got_r.third);
            fails++;
          end
          if (got_r.degen !== exp_r.degen) begin
            $display("%0t: degenerate exp %0b got %0b", $time, exp_r.degen, got_r.degen);
            fails++;
          end
        end
      end
    end
  end
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the point-to-local-frame testbench: clock, reset, point stimulus and
// result back-pressure. Depends on the block, its interfaces and ptlf_checker.
module tb_top;
  localparam int CW        = 24;
  localparam int N_RANDOM  = 800;
  localparam int IDLE_LIMIT = 3000;   // far beyond latency plus the long hold-off
  localparam int HOLD_CYCLES = 400;

  typedef logic [11:0][CW-1:0] point_set_t;  // B xyz, C xyz, E xyz, P xyz

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   sent_cnt;
  int   idle_cycles;
  bit   hold_done;

  ptlf_point_if #(.COORD_WIDTH(CW)) pt ();
  ptlf_local_if #(.COORD_WIDTH(CW)) res ();

  point_to_local_frame #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt),
    .res_o  (res)
  );

  ptlf_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt         (pt),
    .res        (res),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Coordinates come either from the full range or from a small window, so
  // that both tiny axes and saturating projections show up.
  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(3) == 0) return CW'($signed($urandom_range(512)) - 256);
    return CW'($urandom);
  endfunction

  function automatic point_set_t rand_points();
    point_set_t s;
    int kind;
    for (int f = 0; f < 12; f++) s[f] = rand_coord();
    kind = $urandom_range(99);
    if (kind < 4) begin
      s[5:3] = s[2:0];                     // first axis collapses onto the origin
    end else if (kind < 8) begin
      s[8:6] = s[2:0];                     // second axis collapses onto the origin
    end else if (kind < 14) begin
      // Second axis along the first one, scaled by +-2: cross product vanishes.
      for (int c = 0; c < 3; c++) begin
        s[3 + c] = CW'($signed(s[c]) + ($signed(rand_coord()) >>> 3));
        s[6 + c] = CW'($signed(s[c]) + (($signed(s[3 + c]) - $signed(s[c])) *
                   ($urandom_range(1) ? 2 : -2)));
      end
    end
    return s;
  endfunction

  // Holds valid high across back-to-back beats; lowers it only for a gap.
  task automatic send_point(input point_set_t s);
    int gap;
    pt.valid <= 1'b1;
    {pt.point_z, pt.point_y, pt.point_x,
     pt.second_axis_z, pt.second_axis_y, pt.second_axis_x,
     pt.first_axis_z, pt.first_axis_y, pt.first_axis_x,
     pt.origin_z, pt.origin_y, pt.origin_x} <= s;
    do @(posedge clk_i); while (!pt.ready);
    sent_cnt++;
    gap = gap_len();
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic point_set_t make_set(input int bx, by, bz, cx, cy, cz,
                                          ex, ey, ez, px, py, pz);
    return {CW'(pz), CW'(py), CW'(px), CW'(ez), CW'(ey), CW'(ex),
            CW'(cz), CW'(cy), CW'(cx), CW'(bz), CW'(by), CW'(bx)};
  endfunction

  // Receiver: random stalls, plus one long hold-off once traffic is flowing so
  // the pipeline fills up and back-pressures the input.
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sent_cnt >= 150) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        res.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any cycle with a beat on either side resets the idle count.
  always @(posedge clk_i) begin
    if (!rst_ni || (pt.valid && pt.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam int MAXV = 8388607;
  localparam int MINV = -8388608;

  initial begin
    sent_cnt  = 0;
    hold_done = 1'b0;
    rst_ni    <= 1'b0;
    pt.valid  <= 1'b0;
    {pt.point_z, pt.point_y, pt.point_x,
     pt.second_axis_z, pt.second_axis_y, pt.second_axis_x,
     pt.first_axis_z, pt.first_axis_y, pt.first_axis_x,
     pt.origin_z, pt.origin_y, pt.origin_x} <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain axes, both degenerate axes, parallel and anti-parallel
    // axes, skewed axes, range extremes and saturating projections.
    send_point(make_set(0, 0, 0, 256, 0, 0, 0, 256, 0, 300, -400, 500));
    send_point(make_set(10, 20, 30, 10, 20, 30, 0, 256, 0, 1, 2, 3));
    send_point(make_set(10, 20, 30, 99, 0, 0, 10, 20, 30, 1, 2, 3));
    send_point(make_set(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, 9, 9));
    send_point(make_set(0, 0, 0, 1, 2, 3, 2, 4, 6, 100, 50, -70));
    send_point(make_set(0, 0, 0, 1, 2, 3, -3, -6, -9, 100, 50, -70));
    send_point(make_set(0, 0, 0, 256, 0, 0, 256, 256, 0, 700, 900, -300));
    send_point(make_set(0, 0, 0, 1, 0, 0, 0, 0, 1, MAXV, MINV, MAXV));
    send_point(make_set(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV,
                        MAXV, MAXV, MAXV));
    send_point(make_set(MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MAXV,
                        MINV, MINV, MINV));
    send_point(make_set(MINV, 0, 0, MAXV, 0, 0, MINV, MAXV, 0, MAXV, MINV, MAXV));
    send_point(make_set(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV,
                        0, 0, 0));
    send_point(make_set(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0));
    send_point(make_set(0, 0, 0, 1, 1, 1, -1, 1, 1, 255, -255, 128));
    send_point(make_set(100, -200, 300, 100, -200, 301, 101, -200, 300, MAXV, 0, MINV));
    send_point(make_set(0, 0, 0, 3, 4, 0, 0, 0, 7, -12345, 67890, 4242));

    for (int n = 0; n < N_RANDOM; n++) send_point(rand_points());
    pt.valid <= 1'b0;

    wait (pending == 0);
    repeat (150) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
